// ===== design/spit_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the speed profile interpolation table.
package spit_pkg;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_EVAL   = 2'd2;
	localparam logic [1:0] OP_FIND   = 2'd3;

	localparam int MUL_STEPS = 31;
	localparam int DIV_STEPS = 64;

	typedef struct packed {
		logic [31:0] jerk;
		logic [31:0] accel;
		logic [31:0] velocity;
		logic [30:0] ptime;
		logic [31:0] position;
	} point_t;

	localparam int POINT_W = $bits(point_t);

endpackage

// ===== design/speed_profile_interpolation_table_top.sv =====
`timescale 1ns / 1ps
// Top level: point table, halving search sequencer and serial interpolation.
//  channel | dir | handshake           | content
//  s_*     | in  | s_tvalid/s_tready   | command transaction (opcode, point or query)
//  m_*     | out | m_tvalid/m_tready   | result transaction
//  cfg_*   | in  | cfg_valid/cfg_ready | time tolerance write
// Clear and append go straight to the finish state, where the result is registered.
// Search: each probe passes through the probe, wait and compare states; up to log2(depth)+1 probes.
// Evaluate with interpolation runs the serial multiply/divide unit once each for position, velocity, accel and jerk.
// Reset clears the point count; the table needs no clearing pass.
// One command at a time; a finished result holds in the output register while the
// next command is worked on, and waits there if the output stalls.
module speed_profile_interpolation_table_top #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [159:0] s_tdata,  // position, query_time, velocity_in, accel_in, jerk_in, pad
	input  logic [1:0]   s_tuser,  // opcode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [191:0] m_tdata,  // position_out, time_out, velocity_out, accel_out, jerk_out, total_time, pad
	output logic [0:0]   m_tuser,  // ok
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data
);
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_CHECK  = 4'd1;
	localparam logic [3:0] ST_SPROBE = 4'd2;
	localparam logic [3:0] ST_SWAIT  = 4'd3;
	localparam logic [3:0] ST_SCMP   = 4'd4;
	localparam logic [3:0] ST_PICK   = 4'd5;
	localparam logic [3:0] ST_RD0W   = 4'd6;
	localparam logic [3:0] ST_RD0    = 4'd7;
	localparam logic [3:0] ST_RD1W   = 4'd8;
	localparam logic [3:0] ST_RD1    = 4'd9;
	localparam logic [3:0] ST_LGO    = 4'd10;
	localparam logic [3:0] ST_LERP   = 4'd11;
	localparam logic [3:0] ST_FIN    = 4'd12;

	logic [3:0]  state_q;
	logic [1:0]  op_q, qsel_q;
	logic [31:0] pos_q;
	logic [30:0] t_q;
	logic [CW-1:0] count_q, first_q, cnt_q;
	logic [AW-1:0] addr_q;
	logic [30:0] first_time_q, last_time_q;
	logic [31:0] first_pos_q, last_pos_q;
	logic [15:0] tol_q;
	logic        whole_q, ok_q;
	spit_pkg::point_t p0_q, res_q, rd, in_pt;

	logic        accept, wr_ok, we, less, check_ok, lerp_busy, lerp_done;
	logic [31:0] t_plus, lx0, lx1, lres;
	logic [32:0] t_minus;
	logic [CW-1:0] half, k;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	assign in_pt.position = s_tdata[31:0];
	assign in_pt.ptime    = s_tdata[62:32];
	assign in_pt.velocity = s_tdata[94:63];
	assign in_pt.accel    = s_tdata[126:95];
	assign in_pt.jerk     = s_tdata[158:127];

	assign wr_ok = (count_q < CW'(TABLE_DEPTH))
		&& !((count_q != '0) && (last_time_q > in_pt.ptime));
	assign we = accept && (s_tuser == spit_pkg::OP_APPEND) && wr_ok;

	spit_ram #(.WIDTH(spit_pkg::POINT_W), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (count_q[AW-1:0]),
		.wdata (in_pt),
		.raddr (addr_q),
		.rdata (rd)
	);

	assign t_plus  = {1'b0, t_q} + {16'd0, tol_q};
	assign t_minus = {2'b0, t_q} - {17'd0, tol_q};
	always_comb begin
		if (op_q == spit_pkg::OP_EVAL) begin
			check_ok = (count_q >= CW'(2)) && ({1'b0, first_time_q} < t_plus)
				&& ($signed(t_minus) < $signed({2'b0, last_time_q}));
		end else begin
			check_ok = (count_q != '0) && !($signed(pos_q) < $signed(first_pos_q)
				|| $signed(pos_q) > $signed(last_pos_q));
		end
	end

	assign half = cnt_q >> 1;
	assign less = (op_q == spit_pkg::OP_EVAL) ? (rd.ptime < t_q)
		: ($signed(rd.position) < $signed(pos_q));
	assign k = first_q;

	always_comb begin
		unique case (qsel_q)
			2'd0: begin lx0 = p0_q.position; lx1 = rd.position; end
			2'd1: begin lx0 = p0_q.velocity; lx1 = rd.velocity; end
			2'd2: begin lx0 = p0_q.accel;    lx1 = rd.accel;    end
			default: begin lx0 = p0_q.jerk;  lx1 = rd.jerk;     end
		endcase
	end

	spit_lerp u_lerp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_LGO),
		.x0     (lx0),
		.x1     (lx1),
		.num    (t_q - p0_q.ptime),
		.den    (rd.ptime - p0_q.ptime),
		.busy   (lerp_busy),
		.done   (lerp_done),
		.result (lres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			tol_q    <= 16'd1;
			m_tvalid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tol_q <= cfg_data;
			end
			if (m_tvalid && m_tready && state_q != ST_FIN) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						priority case (s_tuser)
							spit_pkg::OP_CLEAR: begin
								count_q <= '0;
								state_q <= ST_FIN;
							end
							spit_pkg::OP_APPEND: begin
								if (wr_ok) begin
									count_q <= count_q + CW'(1);
								end
								state_q <= ST_FIN;
							end
							default: state_q <= ST_CHECK;
						endcase
					end
				end
				ST_CHECK:  state_q <= check_ok ? ST_SPROBE : ST_FIN;
				ST_SPROBE: state_q <= (cnt_q == '0) ? ST_PICK : ST_SWAIT;
				ST_SWAIT:  state_q <= ST_SCMP;
				ST_SCMP:   state_q <= ST_SPROBE;
				ST_PICK: begin
					state_q <= (op_q == spit_pkg::OP_EVAL && k != '0 && k < count_q)
						? ST_RD0W : ST_RD1W;
				end
				ST_RD0W: state_q <= ST_RD0;
				ST_RD0:  state_q <= ST_RD1W;
				ST_RD1W: state_q <= ST_RD1;
				ST_RD1:  state_q <= (op_q == spit_pkg::OP_EVAL && !whole_q) ? ST_LGO : ST_FIN;
				ST_LGO:  state_q <= ST_LERP;
				ST_LERP: begin
					if (lerp_done) begin
						state_q <= (qsel_q == 2'd3) ? ST_FIN : ST_LGO;
					end
				end
				ST_FIN: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q  <= s_tuser;
					pos_q <= in_pt.position;
					t_q   <= in_pt.ptime;
					res_q <= '0;
					ok_q  <= (s_tuser == spit_pkg::OP_CLEAR)
						|| (s_tuser == spit_pkg::OP_APPEND && wr_ok);
					if (we) begin
						if (count_q == '0) begin
							first_time_q <= in_pt.ptime;
							first_pos_q  <= in_pt.position;
						end
						last_time_q <= in_pt.ptime;
						last_pos_q  <= in_pt.position;
					end
				end
			end
			ST_CHECK: begin
				first_q <= '0;
				cnt_q   <= count_q;
			end
			ST_SPROBE: addr_q <= AW'(first_q + half);
			ST_SCMP: begin
				if (less) begin
					first_q <= first_q + half + CW'(1);
					cnt_q   <= cnt_q - half - CW'(1);
				end else begin
					cnt_q <= half;
				end
			end
			ST_PICK: begin
				whole_q <= (k == '0) || (k >= count_q);
				if (op_q == spit_pkg::OP_FIND || k >= count_q) begin
					addr_q <= (k >= count_q) ? AW'(count_q - CW'(1)) : AW'(k);
				end else if (k == '0) begin
					addr_q <= '0;
				end else begin
					addr_q <= AW'(k - CW'(1));
				end
			end
			ST_RD0: begin
				p0_q   <= rd;
				addr_q <= addr_q + AW'(1);
			end
			ST_RD1: begin
				ok_q   <= 1'b1;
				qsel_q <= 2'd0;
				if (op_q == spit_pkg::OP_FIND) begin
					res_q.ptime <= rd.ptime;
				end else if (whole_q) begin
					res_q <= rd;
				end
			end
			ST_LERP: begin
				if (lerp_done) begin
					qsel_q <= qsel_q + 2'd1;
					unique case (qsel_q)
						2'd0: res_q.position <= lres;
						2'd1: res_q.velocity <= lres;
						2'd2: res_q.accel    <= lres;
						default: begin
							res_q.jerk  <= lres;
							res_q.ptime <= t_q;
						end
					endcase
				end
			end
			ST_FIN: begin
				if (!m_tvalid || m_tready) begin
					m_tuser <= ok_q;
					m_tdata <= {2'b0, (count_q != '0) ? (last_time_q - first_time_q) : 31'd0,
						res_q.jerk, res_q.accel, res_q.velocity, res_q.ptime, res_q.position};
				end
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(TABLE_DEPTH))
		else $error("point count beyond table depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tuser == spit_pkg::OP_CLEAR |=> count_q == '0)
		else $error("clear did not empty the table");
	assert property (@(posedge clk) disable iff (!arst_n) s_tready |-> !lerp_busy)
		else $error("interpolator busy while idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN && m_tvalid && !m_tready |=> state_q == ST_FIN)
		else $error("result overwrote a stalled output");
endmodule

// ===== design/spit_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, registered-read RAM.
module spit_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== design/spit_lerp.sv =====
`timescale 1ns / 1ps
// Bit-serial interpolator: x0 + trunc((x1-x0)*num/den), shift-add multiply then restoring divide.
module spit_lerp (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] x0,
	input  logic [31:0] x1,
	input  logic [30:0] num,
	input  logic [30:0] den,
	output logic        busy,
	output logic        done,
	output logic [31:0] result
);
	logic        busy_q, div_q, done_q, neg_q;
	logic [6:0]  cnt_q;
	logic [31:0] x0_q;
	logic [32:0] mag_q;
	logic [64:0] p_q;
	logic [30:0] den_q, rem_q;

	logic [32:0] dx;
	logic [33:0] hsum;
	logic [31:0] r2;
	logic        ge;
	logic [31:0] qv;

	assign dx   = {x1[31], x1} - {x0[31], x0};
	assign hsum = p_q[64:31] + {1'b0, mag_q};
	assign r2   = {rem_q, p_q[63]};
	assign ge   = r2 >= {1'b0, den_q};
	assign qv   = p_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			div_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				div_q  <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q && !div_q) begin
				if (cnt_q == 7'(spit_pkg::MUL_STEPS - 1)) begin
					div_q <= 1'b1;
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + 7'd1;
				end
			end else if (busy_q) begin
				if (cnt_q == 7'(spit_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 7'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x0_q  <= x0;
			neg_q <= dx[32];
			mag_q <= dx[32] ? -dx : dx;
			den_q <= den;
			rem_q <= '0;
			p_q   <= {34'd0, num};
		end else if (busy_q && !div_q) begin
			p_q <= p_q[0] ? {1'b0, hsum, p_q[30:1]} : {1'b0, p_q[64:1]};
		end else if (busy_q) begin
			rem_q     <= ge ? 31'(r2 - {1'b0, den_q}) : r2[30:0];
			p_q[63:0] <= {p_q[62:0], ge};
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = x0_q + (neg_q ? -qv : qv);
endmodule

// ===== dv/tb_speed_profile_interpolation_table_top.sv =====
`timescale 1ns / 1ps
// Testbench: random and directed profile-table commands checked against an in-bench table model.
module tb_speed_profile_interpolation_table_top;

	localparam int DEPTH = 256;
	localparam int NRAND = 120;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct {
		logic [1:0]  op;
		logic [31:0] pos;
		logic [30:0] qt;
		logic [31:0] vel;
		logic [31:0] acc;
		logic [31:0] jrk;
	} cmd_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] pos;
		logic [30:0] tm;
		logic [31:0] vel;
		logic [31:0] acc;
		logic [31:0] jrk;
		logic [30:0] total;
	} res_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [159:0] s_tdata;   // position, query_time, velocity_in, accel_in, jerk_in, pad
	logic [1:0]   s_tuser;   // opcode
	logic         m_tvalid;
	logic         m_tready;
	logic [191:0] m_tdata;   // position_out, time_out, velocity_out, accel_out, jerk_out, total_time, pad
	logic [0:0]   m_tuser;   // ok
	logic         cfg_valid;
	logic         cfg_ready;
	logic [15:0]  cfg_data;

	speed_profile_interpolation_table_top #(.TABLE_DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// profile model state
	longint tbl_pos[DEPTH];
	longint tbl_time[DEPTH];
	longint tbl_vel[DEPTH];
	longint tbl_acc[DEPTH];
	longint tbl_jrk[DEPTH];
	int     tbl_count;
	longint tolerance;

	cmd_t   cmd_queue[$];
	res_t   expected_results[$];
	int     mismatches;
	longint cycle_count;
	int     burst_left;
	int     gap_left;
	int     hold_off;
	bit     long_stall_req;

	function automatic longint sx(logic [31:0] v);
		return longint'(signed'(v));
	endfunction

	function automatic int search_time(longint q);
		int first, cnt, half, probe;
		first = 0;
		cnt = tbl_count;
		while (cnt > 0) begin
			half = cnt / 2;
			probe = first + half;
			if (tbl_time[probe] < q) begin
				first = probe + 1;
				cnt -= half + 1;
			end else begin
				cnt = half;
			end
		end
		return first;
	endfunction

	function automatic int search_pos(longint q);
		int first, cnt, half, probe;
		first = 0;
		cnt = tbl_count;
		while (cnt > 0) begin
			half = cnt / 2;
			probe = first + half;
			if (tbl_pos[probe] < q) begin
				first = probe + 1;
				cnt -= half + 1;
			end else begin
				cnt = half;
			end
		end
		return first;
	endfunction

	function automatic longint lerp(longint x0, longint x1, longint t0, longint t1, longint t);
		return x0 + ((x1 - x0) * (t - t0)) / (t1 - t0);
	endfunction

	function automatic res_t apply_command(cmd_t c);
		res_t r;
		longint t, p;
		int k, m, n;
		r = '{default: '0};
		t = longint'(c.qt);
		p = sx(c.pos);
		n = tbl_count;
		case (c.op)
			spit_pkg::OP_CLEAR: begin
				tbl_count = 0;
				r.ok = 1'b1;
			end
			spit_pkg::OP_APPEND: begin
				if (n < DEPTH && !(n > 0 && tbl_time[n - 1] > t)) begin
					tbl_pos[n] = p;
					tbl_time[n] = t;
					tbl_vel[n] = sx(c.vel);
					tbl_acc[n] = sx(c.acc);
					tbl_jrk[n] = sx(c.jrk);
					tbl_count = n + 1;
					r.ok = 1'b1;
				end
			end
			spit_pkg::OP_EVAL: begin
				if (n >= 2 && tbl_time[0] < t + tolerance && t - tolerance < tbl_time[n - 1]) begin
					k = search_time(t);
					r.ok = 1'b1;
					if (k == 0 || k >= n) begin
						m = (k == 0) ? 0 : n - 1;
						r.pos = 32'(tbl_pos[m]);
						r.tm = 31'(tbl_time[m]);
						r.vel = 32'(tbl_vel[m]);
						r.acc = 32'(tbl_acc[m]);
						r.jrk = 32'(tbl_jrk[m]);
					end else begin
						r.pos = 32'(lerp(tbl_pos[k-1], tbl_pos[k], tbl_time[k-1], tbl_time[k], t));
						r.tm = 31'(t);
						r.vel = 32'(lerp(tbl_vel[k-1], tbl_vel[k], tbl_time[k-1], tbl_time[k], t));
						r.acc = 32'(lerp(tbl_acc[k-1], tbl_acc[k], tbl_time[k-1], tbl_time[k], t));
						r.jrk = 32'(lerp(tbl_jrk[k-1], tbl_jrk[k], tbl_time[k-1], tbl_time[k], t));
					end
				end
			end
			default: begin
				if (n > 0 && !(p < tbl_pos[0] || p > tbl_pos[n - 1])) begin
					k = search_pos(p);
					if (k >= n)
						k = n - 1;
					r.ok = 1'b1;
					r.tm = 31'(tbl_time[k]);
				end
			end
		endcase
		if (tbl_count > 0)
			r.total = 31'(tbl_time[tbl_count - 1] - tbl_time[0]);
		return r;
	endfunction

	function automatic logic [31:0] rnd32();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'd0;
			default: return $urandom();
		endcase
	endfunction

	task automatic push(logic [1:0] op, logic [31:0] pos, logic [30:0] qt,
			logic [31:0] vel, logic [31:0] acc, logic [31:0] jrk);
		cmd_t c;
		c.op = op; c.pos = pos; c.qt = qt; c.vel = vel; c.acc = acc; c.jrk = jrk;
		cmd_queue.insert(cmd_queue.size(), c);
	endtask

	// a clear, then a time-sorted profile with random content and occasional out-of-order appends
	task automatic push_profile(int npts, logic [30:0] tstep_max);
		logic [30:0] t;
		logic [31:0] p;
		int i;
		t = 31'($urandom_range(0, 1000));
		p = $urandom_range(0, 65535) - 32768;
		push(spit_pkg::OP_CLEAR, rnd32(), 31'($urandom()), rnd32(), rnd32(), rnd32());
		for (i = 0; i < npts; i++) begin
			if ($urandom_range(0, 19) == 0)
				push(spit_pkg::OP_APPEND, rnd32(), t - 31'($urandom_range(1, 100)),
					rnd32(), rnd32(), rnd32());
			push(spit_pkg::OP_APPEND, p, t, rnd32(), rnd32(), rnd32());
			if ($urandom_range(0, 5) != 0)
				t += 31'($urandom_range(0, tstep_max));
			p += $urandom_range(0, 200000);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cycle_count <= 0;
		else begin
			cycle_count <= cycle_count + 1;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("** speed_profile_interpolation_table_top: FAILED **");
				$finish;
			end
		end
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		cmd_t c;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				c = cmd_queue.pop_front();
				expected_results.insert(expected_results.size(), apply_command(c));
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (cmd_queue.size() > 0) begin
					c = cmd_queue[0];
					s_tvalid <= 1'b1;
					s_tdata <= {1'b0, c.jrk, c.acc, c.vel, c.qt, c.pos};
					s_tuser <= c.op;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 12);
						if ($urandom_range(0, 2) != 0)
							gap_left <= $urandom_range(1, 60);
					end else
						burst_left <= burst_left - 1;
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	// receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_off <= 0;
		end else if (long_stall_req && hold_off == 0) begin
			hold_off <= 3000;
			m_tready <= 1'b0;
		end else if (hold_off > 1) begin
			hold_off <= hold_off - 1;
			m_tready <= 1'b0;
		end else begin
			hold_off <= 0;
			m_tready <= (cycle_count % 2000 < 700) ? 1'b1 : ($urandom_range(0, 3) != 0);
		end
	end

	// monitor
	always @(posedge clk) begin
		res_t e, a;
		if (arst_n && m_tvalid && m_tready) begin
			a.ok = m_tuser[0];
			{a.total, a.jrk, a.acc, a.vel, a.tm, a.pos} = m_tdata[189:0];
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction ok=%0b", a.ok);
			end else begin
				e = expected_results.pop_front();
				if (e !== a) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp ok=%0b pos=%h t=%h v=%h a=%h j=%h tot=%h | got ok=%0b pos=%h t=%h v=%h a=%h j=%h tot=%h",
							e.ok, e.pos, e.tm, e.vel, e.acc, e.jrk, e.total,
							a.ok, a.pos, a.tm, a.vel, a.acc, a.jrk, a.total);
				end
			end
		end
	end

	task automatic drain();
		while (cmd_queue.size() > 0 || s_tvalid || expected_results.size() > 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_tolerance(logic [15:0] v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		tolerance = v;
	endtask

	initial begin
		int i, ph;
		logic [15:0] tol_set[4];
		mismatches = 0;
		tbl_count = 0;
		tolerance = 1;
		long_stall_req = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty-table cases, ordering, ends, equal times, extremes
		push(spit_pkg::OP_EVAL, '0, 31'd100, '0, '0, '0);
		push(spit_pkg::OP_FIND, 32'd5, '0, '0, '0, '0);
		push(spit_pkg::OP_APPEND, 32'h8000_0000, 31'd1000, 32'h7fff_ffff, 32'h8000_0000,
			32'hffff_ffff);
		push(spit_pkg::OP_EVAL, '0, 31'd1000, '0, '0, '0);
		push(spit_pkg::OP_APPEND, 32'd0, 31'd999, '0, '0, '0);
		push(spit_pkg::OP_APPEND, 32'h7fff_ffff, 31'd1000, 32'h8000_0000, 32'h7fff_ffff, 32'd0);
		push(spit_pkg::OP_APPEND, 32'h7fff_ffff, 31'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
			32'h1234);
		push(spit_pkg::OP_EVAL, '0, 31'd999, '0, '0, '0);
		push(spit_pkg::OP_EVAL, '0, 31'd1000, '0, '0, '0);
		push(spit_pkg::OP_EVAL, '0, 31'h4000_0000, '0, '0, '0);
		push(spit_pkg::OP_EVAL, '0, 31'h7fff_fffe, '0, '0, '0);
		push(spit_pkg::OP_EVAL, '0, 31'h7fff_ffff, '0, '0, '0);
		push(spit_pkg::OP_EVAL, '0, 31'd0, '0, '0, '0);
		push(spit_pkg::OP_FIND, 32'h8000_0000, '0, '0, '0, '0);
		push(spit_pkg::OP_FIND, 32'h7fff_ffff, '0, '0, '0, '0);
		push(spit_pkg::OP_FIND, 32'd0, '0, '0, '0, '0);
		push(spit_pkg::OP_CLEAR, '0, '0, '0, '0, '0);
		push(spit_pkg::OP_FIND, 32'h8000_0000, '0, '0, '0, '0);
		for (i = 0; i < DEPTH + 1; i++)
			push(spit_pkg::OP_APPEND, 32'(i * 3), 31'(i), $urandom(), $urandom(), $urandom());
		push(spit_pkg::OP_EVAL, '0, 31'd77, '0, '0, '0);
		push(spit_pkg::OP_FIND, 32'd400, '0, '0, '0, '0);
		drain();

		tol_set = '{16'd0, 16'hffff, 16'd1, 16'd300};
		for (ph = 0; ph < 4; ph++) begin
			write_tolerance(tol_set[ph]);
			if (ph == 1)
				long_stall_req = 1'b1;
			for (i = 0; i < NRAND / 4; ) begin
				int npts;
				npts = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
				push_profile(npts, ($urandom_range(0, 1) != 0) ? 31'd200 : 31'h0100_0000);
				repeat ($urandom_range(3, 8)) begin
					case ($urandom_range(0, 4))
						0: push(spit_pkg::OP_FIND, rnd32(), 31'($urandom()), rnd32(), rnd32(),
							rnd32());
						1: push(spit_pkg::OP_FIND, $urandom_range(0, 800000) - 32768,
							31'($urandom()), rnd32(), rnd32(), rnd32());
						2: push(spit_pkg::OP_EVAL, rnd32(), 31'($urandom()), rnd32(), rnd32(),
							rnd32());
						default: push(spit_pkg::OP_EVAL, rnd32(), 31'($urandom_range(0, 6000)),
							rnd32(), rnd32(), rnd32());
					endcase
					i++;
				end
				i += npts;
			end
			drain();
			long_stall_req = 1'b0;
		end

		if (mismatches == 0 && expected_results.size() == 0)
			$display("** speed_profile_interpolation_table_top: PASSED **");
		else
			$display("** speed_profile_interpolation_table_top: FAILED **");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/spit_pkg.sv
design/spit_ram.sv
design/spit_lerp.sv
design/speed_profile_interpolation_table_top.sv
dv/tb_speed_profile_interpolation_table_top.sv
